/* rtl/bcpd_pkg.sv */
// Shared types and constants for the button click pattern detector.
`default_nettype none
package bcpd_pkg;

  localparam int DURATION_BITS = 20;
  localparam int DEBOUNCE_W    = 10;
  localparam int WINDOW_W      = 12;
  localparam int HOLD_W        = 16;
  localparam int TALLY_W       = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = WINDOW_W'(400);
  localparam logic [HOLD_W-1:0]     HOLD_RESET     = HOLD_W'(3000);

  // event queue depth, power of two, at least two
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_DEB_PRESS    = 3'd1,
    ST_PRESSED      = 3'd2,
    ST_LONG_PRESS   = 3'd3,
    ST_DEB_RELEASE  = 3'd4,
    ST_WAIT_RELEASE = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    EV_SINGLE       = 2'd0,
    EV_DOUBLE       = 2'd1,
    EV_LONG         = 2'd2,
    EV_LONG_RELEASE = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2
  } reg_index_t;

  typedef struct packed {
    event_kind_t              kind;
    logic [DURATION_BITS-1:0] dur;
    logic [TALLY_W-1:0]       total;
    state_t                   state;
    logic                     last;
  } evt_t;

  typedef struct packed {
    logic [1:0] n;
    evt_t       e0;
    evt_t       e1;
  } push_t;

endpackage
`default_nettype wire

/* rtl/bcpd_evt_fifo.sv */
// Event queue taking up to two requests per cycle, one out when out_ready.
`default_nettype none
module bcpd_evt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  bcpd_pkg::push_t push,
  output logic           room_for_two,
  output logic           out_valid,
  input  logic           out_ready,
  output bcpd_pkg::evt_t out_evt
);
  import bcpd_pkg::*;

  evt_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign out_valid    = (count != '0);
  assign out_evt      = mem[rd_ptr];
  assign pop          = out_valid && out_ready;
  assign room_for_two = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign count_next   = count + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count <= CNT_W'(FIFO_DEPTH - 2)))
    else $error("event queue pushed without room");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rd_ptr))
    else $error("stalled event lost");

  a_two_needs_pair: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> !push.e0.last && push.e1.last)
    else $error("paired request marks wrong last");

endmodule
`default_nettype wire

/* rtl/button_click_pattern_detector.sv */
// Top level: debounced single, double and long press detection per ms tick.
// A tick's events are written into the event queue when the tick is accepted and are read out of it in order.
// One tick per cycle while in_ready is high; a tick giving two events queues both, and they are read out one at a time.
// in_ready drops while the four-entry event queue has fewer than two free slots.
// Reset (synchronous): waits for a released level, counts cleared, registers defaulted.
`default_nettype none
module button_click_pattern_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [bcpd_pkg::DURATION_BITS-1:0] held_ms,
  output logic [31:0] press_total,
  output logic [2:0]  fsm_state,
  output logic        last
);
  import bcpd_pkg::*;

  localparam logic [DURATION_BITS-1:0] HELD_MAX = {DURATION_BITS{1'b1}};
  localparam int CMP_W = 33;

  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [WINDOW_W-1:0]   double_click_ms;
  logic [HOLD_W-1:0]     long_press_ms;

  state_t                   mode, mode_next;
  logic                     armed, armed_next;
  logic                     prior_level;
  logic [1:0]               click_tally, click_tally_next;
  logic [DEBOUNCE_W-1:0]    debounce_left, debounce_left_next;
  logic [HOLD_W-1:0]        hold_left, hold_left_next;
  logic [WINDOW_W-1:0]      window_left, window_left_next;
  logic [DURATION_BITS-1:0] held_time, held_time_next;
  logic [TALLY_W-1:0]       press_tally, press_tally_next;

  logic        accept;
  logic        cfg_write;
  logic [1:0]  ev_n;
  event_kind_t ev0_kind, ev1_kind;
  logic [DURATION_BITS-1:0] ev0_dur, ev1_dur;
  push_t       push;
  evt_t        out_evt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      double_click_ms <= WINDOW_RESET;
      long_press_ms   <= HOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[3:2]))
        REG_DEBOUNCE: debounce_ms     <= pwdata[DEBOUNCE_W-1:0];
        REG_DOUBLE:   double_click_ms <= pwdata[WINDOW_W-1:0];
        REG_LONG:     long_press_ms   <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_DEBOUNCE: prdata = 32'(debounce_ms);
      REG_DOUBLE:   prdata = 32'(double_click_ms);
      REG_LONG:     prdata = 32'(long_press_ms);
      default:      prdata = '0;
    endcase
  end

  // one tick: held time, level handling, then window, hold and debounce counts
  always_comb begin
    mode_next          = mode;
    armed_next         = armed;
    click_tally_next   = click_tally;
    debounce_left_next = debounce_left;
    hold_left_next     = hold_left;
    window_left_next   = window_left;
    held_time_next     = held_time;
    press_tally_next   = press_tally;
    ev_n     = 2'd0;
    ev0_kind = EV_SINGLE;
    ev1_kind = EV_SINGLE;
    ev0_dur  = '0;
    ev1_dur  = '0;

    if ((mode == ST_PRESSED || mode == ST_LONG_PRESS || mode == ST_DEB_RELEASE)
        && held_time != HELD_MAX) begin
      held_time_next = held_time + DURATION_BITS'(1);
    end

    if (mode == ST_WAIT_RELEASE) begin
      if (button_level) begin
        armed_next = 1'b1;
        mode_next  = ST_IDLE;
      end
    end else if (button_level != prior_level) begin
      case (mode)
        ST_PRESSED: begin
          if (button_level) begin
            mode_next          = ST_DEB_RELEASE;
            hold_left_next     = '0;
            debounce_left_next = (debounce_ms == '0) ? DEBOUNCE_W'(1) : debounce_ms;
          end
        end
        ST_LONG_PRESS: begin
          if (button_level) begin
            ev_n      = 2'd1;
            ev0_kind  = EV_LONG_RELEASE;
            ev0_dur   = held_time_next;
            mode_next = ST_IDLE;
          end
        end
        ST_DEB_PRESS, ST_DEB_RELEASE: ;
        default: begin
          if (!armed) begin
            mode_next = ST_WAIT_RELEASE;
          end else if (!button_level) begin
            mode_next          = ST_DEB_PRESS;
            debounce_left_next = (debounce_ms == '0) ? DEBOUNCE_W'(1) : debounce_ms;
          end
        end
      endcase
    end

    if (window_left_next != '0) begin
      window_left_next = window_left_next - WINDOW_W'(1);
      if (window_left_next == '0) begin
        if (click_tally_next == 2'd1) begin
          if (ev_n == 2'd0) begin
            ev0_kind = EV_SINGLE;
            ev0_dur  = '0;
          end else begin
            ev1_kind = EV_SINGLE;
            ev1_dur  = '0;
          end
          ev_n = ev_n + 2'd1;
        end
        click_tally_next = 2'd0;
      end
    end

    if (hold_left_next != '0) begin
      hold_left_next = hold_left_next - HOLD_W'(1);
      if (hold_left_next == '0 && mode_next == ST_PRESSED) begin
        if (ev_n == 2'd0) begin
          ev0_kind = EV_LONG;
          ev0_dur  = held_time_next;
        end else begin
          ev1_kind = EV_LONG;
          ev1_dur  = held_time_next;
        end
        ev_n      = ev_n + 2'd1;
        mode_next = ST_LONG_PRESS;
      end
    end

    if (debounce_left_next != '0) begin
      debounce_left_next = debounce_left_next - DEBOUNCE_W'(1);
      if (debounce_left_next == '0) begin
        if (mode_next == ST_DEB_PRESS) begin
          if (!button_level) begin
            held_time_next   = '0;
            press_tally_next = press_tally + TALLY_W'(1);
            mode_next        = ST_PRESSED;
            hold_left_next   = (long_press_ms == '0) ? HOLD_W'(1) : long_press_ms;
          end else begin
            mode_next = ST_IDLE;
          end
        end else if (mode_next == ST_DEB_RELEASE) begin
          if (!button_level) begin
            // bounce back: still pressed, restart the hold count
            mode_next      = ST_PRESSED;
            hold_left_next = (long_press_ms == '0) ? HOLD_W'(1) : long_press_ms;
          end else if (CMP_W'(held_time_next) < CMP_W'(long_press_ms)) begin
            click_tally_next = click_tally_next + 2'd1;
            if (click_tally_next == 2'd1) begin
              window_left_next = (double_click_ms == '0) ? WINDOW_W'(1) : double_click_ms;
            end else begin
              window_left_next = '0;
              if (ev_n == 2'd0) begin
                ev0_kind = EV_DOUBLE;
                ev0_dur  = '0;
              end else begin
                ev1_kind = EV_DOUBLE;
                ev1_dur  = '0;
              end
              ev_n             = ev_n + 2'd1;
              click_tally_next = 2'd0;
            end
            mode_next = ST_IDLE;
          end else begin
            mode_next = ST_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ST_WAIT_RELEASE;
      armed         <= 1'b0;
      prior_level   <= 1'b1;
      click_tally   <= 2'd0;
      debounce_left <= '0;
      hold_left     <= '0;
      window_left   <= '0;
      held_time     <= '0;
      press_tally   <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      armed         <= armed_next;
      prior_level   <= button_level;
      click_tally   <= click_tally_next;
      debounce_left <= debounce_left_next;
      hold_left     <= hold_left_next;
      window_left   <= window_left_next;
      held_time     <= held_time_next;
      press_tally   <= press_tally_next;
    end
  end

  // queue request for this tick's events
  always_comb begin
    push.n        = accept ? ev_n : 2'd0;
    push.e0.kind  = ev0_kind;
    push.e0.dur   = ev0_dur;
    push.e0.total = press_tally_next;
    push.e0.state = mode_next;
    push.e0.last  = (ev_n == 2'd1);
    push.e1.kind  = ev1_kind;
    push.e1.dur   = ev1_dur;
    push.e1.total = press_tally_next;
    push.e1.state = mode_next;
    push.e1.last  = 1'b1;
  end

  bcpd_evt_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_evt      (out_evt)
  );

  assign event_kind  = out_evt.kind;
  assign held_ms     = out_evt.dur;
  assign press_total = out_evt.total;
  assign fsm_state   = out_evt.state;
  assign last        = out_evt.last;

  a_arm_on_release: assert property (@(posedge clk) disable iff (rst)
    accept && button_level && mode == ST_WAIT_RELEASE |=> mode == ST_IDLE && armed)
    else $error("release level did not arm");

  a_deb_press_counting: assert property (@(posedge clk) disable iff (rst)
    mode == ST_DEB_PRESS |-> debounce_left != '0)
    else $error("press debounce without count");

  a_deb_release_counting: assert property (@(posedge clk) disable iff (rst)
    mode == ST_DEB_RELEASE |-> debounce_left != '0)
    else $error("release debounce without count");

  a_pressed_hold_running: assert property (@(posedge clk) disable iff (rst)
    mode == ST_PRESSED |-> hold_left != '0)
    else $error("pressed without hold count");

endmodule
`default_nettype wire
